// File: rtl/core/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg: shared types and codes of the dirty rectangle refresh planner
// Holds the request mode codes and the refresh command codes.
// ----------------------------------------------------------------------------
package drp_pkg;

    // request mode on the input channel
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    // refresh command on the result channel
    typedef enum logic [1:0] {
        CMD_FULL      = 2'd0,
        CMD_CURRENT   = 2'd1,
        CMD_SYNC_PREV = 2'd2
    } cmd_t;

endpackage

// File: rtl/core/dirty_rect_refresh_planner.sv
// ----------------------------------------------------------------------------
// dirty_rect_refresh_planner: dirty rectangle store and refresh planner
// Merges dirty rectangles into a small slot store and turns polls into
// full or partial panel refresh commands.
// ----------------------------------------------------------------------------
// Every request goes into an input register and is worked off from there
// by one pass of short logic that updates the slot store and, on a
// firing poll, pushes its commands into a two-entry result buffer that
// drives the m_ ports. An add request never produces a result; a poll with
// a refresh pending and the panel idle produces one command (full refresh,
// or one current-only partial) or two (sync-previous partial for slot 0,
// then current-only partial for the last slot), and clears the store. A
// poll with the panel busy or nothing pending is dropped without a result.
// The block takes one request per cycle unless held back; the first
// command of a poll passes the input register, then the result buffer,
// whose entry 0 drives the m_ ports. Back-pressure comes from the result
// buffer: a poll is worked off only once the buffer has room for all its
// commands, so a consumer that stalls m_ready holds back the input once
// the input register is also full. Adds pass freely while results wait.
// ----------------------------------------------------------------------------
module dirty_rect_refresh_planner #(
    parameter int SLOTS      = 2,
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [COORD_BITS-1:0] s_rect_x1,
    input  logic [COORD_BITS-1:0] s_rect_y1,
    input  logic [COORD_BITS-1:0] s_rect_x2,
    input  logic [COORD_BITS-1:0] s_rect_y2,
    input  logic                  s_panel_busy,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output drp_pkg::cmd_t         m_command,
    output logic [COORD_BITS-1:0] m_start_x,
    output logic [COORD_BITS-1:0] m_start_y,
    output logic [COORD_BITS:0]   m_width,
    output logic [COORD_BITS:0]   m_height,
    output logic                  m_last
);
    import drp_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SZ_W  = COORD_BITS + 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
    } rect_t;

    typedef struct packed {
        logic  mode;
        rect_t rect;
        logic  busy;
    } item_t;

    typedef struct packed {
        cmd_t                  command;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [SZ_W-1:0]       width;
        logic [SZ_W-1:0]       height;
        logic                  last;
    } res_t;

    // True when the two rectangles overlap or touch, with no pixel between them.
    function automatic logic near_rect(rect_t a, rect_t b);
        logic gap;
        begin
            gap = ({1'b0, a.x2} + SZ_W'(1) < {1'b0, b.x1}) ||
                  ({1'b0, b.x2} + SZ_W'(1) < {1'b0, a.x1}) ||
                  ({1'b0, a.y2} + SZ_W'(1) < {1'b0, b.y1}) ||
                  ({1'b0, b.y2} + SZ_W'(1) < {1'b0, a.y1});
            near_rect = !gap;
        end
    endfunction

    function automatic rect_t cover_rect(rect_t d, rect_t s);
        rect_t o;
        begin
            o    = d;
            o.x1 = (s.x1 < d.x1) ? s.x1 : d.x1;
            o.y1 = (s.y1 < d.y1) ? s.y1 : d.y1;
            o.x2 = (s.x2 > d.x2) ? s.x2 : d.x2;
            o.y2 = (s.y2 > d.y2) ? s.y2 : d.y2;
            cover_rect = o;
        end
    endfunction

    function automatic res_t make_res(cmd_t c, rect_t r, logic l);
        res_t o;
        begin
            o.command = c;
            o.start_x = r.x1;
            o.start_y = r.y1;
            o.width   = SZ_W'(r.x2) - SZ_W'(r.x1) + SZ_W'(1);
            o.height  = SZ_W'(r.y2) - SZ_W'(r.y1) + SZ_W'(1);
            o.last    = l;
            make_res  = o;
        end
    endfunction

    // input register
    logic  item_valid_reg;
    item_t item_reg;

    // slot store
    rect_t            slot_reg  [SLOTS];
    rect_t            slot_next [SLOTS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             pend_reg, pend_next;

    // result buffer: entry 0 drives the m_ ports
    res_t       ent0_reg, ent0_next;
    res_t       ent1_reg, ent1_next;
    logic [1:0] out_cnt_reg, out_cnt_next;

    logic       is_add;
    logic       fire;
    logic [1:0] need;
    logic [1:0] push;
    res_t       res0, res1;
    logic       pop;
    logic [1:0] cnt_after_pop;
    logic       item_go;
    logic       hit;

    // ------------------------------------------------------------------
    // Poll decision and commands for the request in the input register
    // ------------------------------------------------------------------
    always_comb begin
        is_add = (item_reg.mode == MODE_ADD);
        fire   = item_valid_reg && !is_add && pend_reg && !item_reg.busy;
        res0   = make_res(CMD_FULL, '0, 1'b1);
        res1   = make_res(CMD_FULL, '0, 1'b1);
        need   = 2'd0;
        // overflow or an empty store: one full refresh with a zero region
        if (ovf_reg || count_reg == '0) begin
            res0.start_x = '0;
            res0.start_y = '0;
            res0.width   = '0;
            res0.height  = '0;
            need         = 2'd1;
        end else if (count_reg == CNT_W'(1) || SLOTS < 2) begin
            res0 = make_res(CMD_CURRENT, slot_reg[0], 1'b1);
            need = 2'd1;
        end else begin
            res0 = make_res(CMD_SYNC_PREV, slot_reg[0], 1'b0);
            res1 = make_res(CMD_CURRENT, slot_reg[SLOTS-1], 1'b1);
            need = 2'd2;
        end
        if (!fire) begin
            need = 2'd0;
        end
    end

    // Work off the request once the buffer, after this cycle's pop, has room.
    assign m_valid       = (out_cnt_reg != 2'd0);
    assign pop           = m_valid && m_ready;
    assign cnt_after_pop = out_cnt_reg - {1'b0, pop};
    assign item_go       = item_valid_reg && ({1'b0, cnt_after_pop} + {1'b0, need} <= 3'd2);
    assign s_ready       = !item_valid_reg || item_go;
    assign push          = item_go ? need : 2'd0;

    // ------------------------------------------------------------------
    // Slot store update
    // ------------------------------------------------------------------
    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        hit        = 1'b0;
        if (item_go) begin
            if (is_add) begin
                pend_next = 1'b1;
                // merge into the first used slot that is near; no recheck after
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && CNT_W'(i) < count_reg &&
                        near_rect(slot_reg[i], item_reg.rect)) begin
                        slot_next[i] = cover_rect(slot_reg[i], item_reg.rect);
                        hit          = 1'b1;
                    end
                end
                if (!hit) begin
                    if (count_reg < CNT_W'(SLOTS)) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (CNT_W'(i) == count_reg) begin
                                slot_next[i] = item_reg.rect;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end else if (fire) begin
                // clear the store after issuing the refresh
                pend_next  = 1'b0;
                count_next = '0;
                ovf_next   = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    slot_next[i] = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: shift on pop, append new commands behind what stays
    // ------------------------------------------------------------------
    always_comb begin
        ent0_next    = ent0_reg;
        ent1_next    = ent1_reg;
        out_cnt_next = cnt_after_pop + push;
        case (cnt_after_pop)
            2'd0: begin
                ent0_next = res0;
                ent1_next = res1;
            end
            2'd1: begin
                ent0_next = pop ? ent1_reg : ent0_reg;
                ent1_next = res0;
            end
            default: begin
                ent0_next = ent0_reg;
                ent1_next = ent1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            out_cnt_reg    <= 2'd0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                item_valid_reg <= s_valid;
            end
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            out_cnt_reg <= out_cnt_next;
            slot_reg    <= slot_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode    <= s_mode;
            item_reg.rect.x1 <= s_rect_x1;
            item_reg.rect.y1 <= s_rect_y1;
            item_reg.rect.x2 <= s_rect_x2;
            item_reg.rect.y2 <= s_rect_y2;
            item_reg.busy    <= s_panel_busy;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign m_command = ent0_reg.command;
    assign m_start_x = ent0_reg.start_x;
    assign m_start_y = ent0_reg.start_y;
    assign m_width   = ent0_reg.width;
    assign m_height  = ent0_reg.height;
    assign m_last    = ent0_reg.last;

endmodule

// File: rtl/core/drp_checker.sv
// ----------------------------------------------------------------------------
// drp_checker: port-level checks for the refresh planner
// Watches the result channel and the command sequence of each poll.
// ----------------------------------------------------------------------------
module drp_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input drp_pkg::cmd_t         m_command,
    input logic [COORD_BITS-1:0] m_start_x,
    input logic [COORD_BITS:0]   m_width,
    input logic                  m_last
);
    import drp_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a full refresh is a single command with an empty region
    a_full_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command == CMD_FULL |-> m_last && m_start_x == '0 && m_width == '0)
        else $error("full refresh malformed");

    // a sync-previous partial is always followed at once by the closing current-only one
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_command == CMD_SYNC_PREV && !m_last
        |=> m_valid && m_command == CMD_CURRENT && m_last)
        else $error("sync-previous not followed by current-only last");

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind dirty_rect_refresh_planner drp_checker #(.COORD_BITS(COORD_BITS)) u_drp_checker (.*);
